[sv/spv_pkg.sv]
// spv_pkg: types, constants and helper functions for the sensor packet validator.
// No dependencies; imported by the channel interfaces, the top level and its checker.

package spv_pkg;

	// Verdict codes; ST_SHORT to ST_TYPE are in check order, but ST_LONG is checked first
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_MAGIC   = 3'd2,
		ST_VERSION = 3'd3,
		ST_CRC     = 3'd4,
		ST_LENGTH  = 3'd5,
		ST_TYPE    = 3'd6,
		ST_LONG    = 3'd7
	} status_t;

	// Header byte positions
	localparam logic [7:0] POS_MAGIC   = 8'd0;
	localparam logic [7:0] POS_VERSION = 8'd1;
	localparam logic [7:0] POS_LENGTH  = 8'd2;
	localparam logic [7:0] POS_TYPE    = 8'd3;
	localparam logic [7:0] POS_NODE_HI = 8'd4;
	localparam logic [7:0] POS_NODE_LO = 8'd5;
	localparam logic [7:0] POS_CRC_HI  = 8'd6;
	localparam logic [7:0] POS_CRC_LO  = 8'd7;

	localparam logic [7:0]  HDR_BYTES        = 8'd8;
	localparam logic [7:0]  MAX_PACKET_BYTES = 8'd127;
	localparam logic [7:0]  COUNT_SAT        = 8'd255;
	localparam logic [7:0]  LEN_OUT_MAX      = 8'd127;
	localparam logic [7:0]  MAGIC_VALUE      = 8'hAC;
	localparam logic [7:0]  VERSION_VALUE    = 8'h01;
	localparam logic [15:0] CRC_POLY         = 16'h1021;
	localparam logic [15:0] SEED_AT_RESET    = 16'h1D0F;

	localparam logic [7:0] TYPE_A = 8'h11;
	localparam logic [7:0] TYPE_B = 8'h12;
	localparam logic [7:0] TYPE_C = 8'h99;
	localparam logic [7:0] TYPE_D = 8'h31;

	// One byte of CRC-16/CCITT, MSB first, no reflection
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic type_known(input logic [7:0] t);
		return t inside {TYPE_A, TYPE_B, TYPE_C, TYPE_D};
	endfunction

endpackage

[sv/spv_channels.sv]
// spv_channels: valid/ready channel interfaces for packet bytes, verdicts and seed writes.
// Depends on spv_pkg.

interface spv_byte_if import spv_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface spv_verdict_if import spv_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  message_type;
	logic [15:0] source_node;
	logic [7:0]  length_field;
	logic [6:0]  received_length;

	modport source (output valid, status, message_type, source_node, length_field,
		received_length, input ready);
	modport sink   (input valid, status, message_type, source_node, length_field,
		received_length, output ready);
endinterface

interface spv_seed_if import spv_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[sv/sensor_packet_validator.sv]
// sensor_packet_validator: byte-serial packet checker with CRC-16 and header capture.
// Depends on spv_pkg and the interfaces in spv_channels.
//
//  channel  | dir | payload                                          | transaction
//  ---------+-----+--------------------------------------------------+---------------------------
//  pkt      | in  | data_byte[7:0], last_byte                        | one packet byte
//  verdict  | out | status[2:0], message_type, source_node[15:0],    | one verdict per packet,
//           |     | length_field, received_length[6:0]               | after the last byte
//  seed     | in  | data[15:0]                                       | CRC seed write
//
// One byte per cycle, sustained unless a last byte waits for the verdict register (below).
// A byte is registered on input (_s1); the CRC update, header capture and verdict are then
// computed combinationally into the packet state and the verdict register, which is loaded
// when the last byte leaves the input register.
// Reset clears the packet state, loads the seed register with 0x1D0F and empties
// both registers. Only a last byte waits for a full verdict register; other bytes
// move on regardless, so pkt.ready falls only while a verdict is stalled and
// another last byte is queued behind it.

module sensor_packet_validator import spv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	spv_byte_if.sink      pkt,
	spv_verdict_if.source verdict,
	spv_seed_if.sink      seed
);

	// CRC seed register; the seed is picked up on the first byte of each packet
	logic [15:0] seed_q;

	// Input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Packet state
	logic [7:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  magic_q, version_q, length_q, type_q;
	logic [15:0] node_q, crc_seen_q;

	// Verdict register
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  type_out_q, length_out_q;
	logic [15:0] node_out_q;
	logic [6:0]  rxlen_out_q;

	// Next-state values for the byte in the input register
	logic [15:0] crc_base, crc_nxt;
	logic [7:0]  fed, count_nxt;
	logic [7:0]  magic_nxt, version_nxt, length_nxt, type_nxt;
	logic [15:0] node_nxt, crc_seen_nxt;
	status_t     status_nxt;
	logic [6:0]  rxlen_nxt;
	logic        advance, out_free;

	assign seed.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_AT_RESET;
		end else if (seed.valid) begin
			seed_q <= seed.data;
		end
	end

	// Verdict register free this cycle, or being emptied by the sink
	assign out_free = !out_valid_q || verdict.ready;
	// Only a last byte needs room in the verdict register
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			data_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	// Header capture and CRC feed; the CRC bytes themselves enter as zero
	always_comb begin
		magic_nxt    = magic_q;
		version_nxt  = version_q;
		length_nxt   = length_q;
		type_nxt     = type_q;
		node_nxt     = node_q;
		crc_seen_nxt = crc_seen_q;
		fed          = data_s1;
		case (count_q)
			POS_MAGIC:   magic_nxt = data_s1;
			POS_VERSION: version_nxt = data_s1;
			POS_LENGTH:  length_nxt = data_s1;
			POS_TYPE:    type_nxt = data_s1;
			POS_NODE_HI: node_nxt = {data_s1, node_q[7:0]};
			POS_NODE_LO: node_nxt = {node_q[15:8], data_s1};
			POS_CRC_HI: begin
				crc_seen_nxt = {data_s1, crc_seen_q[7:0]};
				fed          = 8'h00;
			end
			POS_CRC_LO: begin
				crc_seen_nxt = {crc_seen_q[15:8], data_s1};
				fed          = 8'h00;
			end
			default: ;
		endcase
	end

	assign crc_base  = (count_q == POS_MAGIC) ? seed_q : crc_q;
	assign crc_nxt   = crc16_byte(crc_base, fed);
	assign count_nxt = (count_q == COUNT_SAT) ? count_q : count_q + 8'd1;
	assign rxlen_nxt = (count_nxt > LEN_OUT_MAX) ? LEN_OUT_MAX[6:0] : count_nxt[6:0];

	// Checks in priority order
	always_comb begin
		if (count_nxt > MAX_PACKET_BYTES) begin
			status_nxt = ST_LONG;
		end else if (count_nxt < HDR_BYTES) begin
			status_nxt = ST_SHORT;
		end else if (magic_nxt != MAGIC_VALUE) begin
			status_nxt = ST_MAGIC;
		end else if (version_nxt != VERSION_VALUE) begin
			status_nxt = ST_VERSION;
		end else if (crc_seen_nxt != crc_nxt) begin
			status_nxt = ST_CRC;
		end else if (count_nxt < length_nxt) begin
			status_nxt = ST_LENGTH;
		end else if (!type_known(type_nxt)) begin
			status_nxt = ST_TYPE;
		end else begin
			status_nxt = ST_OK;
		end
	end

	// Packet state: updated per byte, cleared after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			crc_q      <= SEED_AT_RESET;
			magic_q    <= '0;
			version_q  <= '0;
			length_q   <= '0;
			type_q     <= '0;
			node_q     <= '0;
			crc_seen_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				count_q    <= '0;
				crc_q      <= seed_q;
				magic_q    <= '0;
				version_q  <= '0;
				length_q   <= '0;
				type_q     <= '0;
				node_q     <= '0;
				crc_seen_q <= '0;
			end else begin
				count_q    <= count_nxt;
				crc_q      <= crc_nxt;
				magic_q    <= magic_nxt;
				version_q  <= version_nxt;
				length_q   <= length_nxt;
				type_q     <= type_nxt;
				node_q     <= node_nxt;
				crc_seen_q <= crc_seen_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q     <= status_nxt;
			type_out_q   <= type_nxt;
			node_out_q   <= node_nxt;
			length_out_q <= length_nxt;
			rxlen_out_q  <= rxlen_nxt;
		end
	end

	assign verdict.valid           = out_valid_q;
	assign verdict.status          = status_q;
	assign verdict.message_type    = type_out_q;
	assign verdict.source_node     = node_out_q;
	assign verdict.length_field    = length_out_q;
	assign verdict.received_length = rxlen_out_q;

endmodule

[sv/spv_checker.sv]
// spv_checker: port-level assertions for sensor_packet_validator, bound to the top level.
// Depends on spv_pkg.

module spv_checker import spv_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        pkt_ready,
	input logic        verdict_valid,
	input logic        verdict_ready,
	input logic [2:0]  status,
	input logic [7:0]  message_type,
	input logic [15:0] source_node,
	input logic [7:0]  length_field,
	input logic [6:0]  received_length
);

	// A stalled verdict holds its payload
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_ready |=> verdict_valid && $stable(status)
		&& $stable(message_type) && $stable(source_node) && $stable(length_field)
		&& $stable(received_length))
		else $error("verdict changed while stalled");

	// Byte input only backs up behind a stalled verdict
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt_ready |-> verdict_valid && !verdict_ready)
		else $error("byte input stalled without a stalled verdict");

	// A short packet never reaches the header length
	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && status == ST_SHORT |-> received_length < HDR_BYTES[6:0])
		else $error("short verdict with full header count");

	// A good packet has a known type and covers its length field
	a_ok_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && status == ST_OK |->
		({1'b0, received_length} >= length_field) && (received_length >= HDR_BYTES[6:0])
		&& (message_type == TYPE_A || message_type == TYPE_B
		|| message_type == TYPE_C || message_type == TYPE_D))
		else $error("ok verdict inconsistent with reported header");

	// Too long means the count passed the limit and saturated
	a_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && status == ST_LONG |-> received_length == LEN_OUT_MAX[6:0])
		else $error("long verdict without saturated count");

endmodule

bind sensor_packet_validator spv_checker u_spv_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pkt_ready       (pkt.ready),
	.verdict_valid   (verdict.valid),
	.verdict_ready   (verdict.ready),
	.status          (verdict.status),
	.message_type    (verdict.message_type),
	.source_node     (verdict.source_node),
	.length_field    (verdict.length_field),
	.received_length (verdict.received_length)
);

[verif/tb_sensor_packet_validator.sv]
// tb_sensor_packet_validator: self-checking testbench for the sensor packet validator.
// Depends on spv_pkg, the channel interfaces in spv_channels and the RTL top level.
// Directed packets from a table, then random packets under three idling regimes.

module tb_sensor_packet_validator;
	import spv_pkg::*;

	// One verdict as it leaves the block
	typedef struct packed {
		status_t     status;
		logic [7:0]  mtype;
		logic [15:0] node;
		logic [7:0]  len;
		logic [6:0]  rx;
	} verdict_t;

	// How header bytes 6 and 7 are filled in before a packet goes out
	typedef enum logic [1:0] {
		CRC_RAW,   // as written in the table
		CRC_GOOD,  // matching CRC over the packet
		CRC_FLIP   // matching CRC with its low bit inverted
	} crc_mode_t;

	// One directed packet: header bytes 0..7 from the top of hdr, payload bytes all fill
	typedef struct packed {
		logic [8:0]  nbytes;
		logic [63:0] hdr;
		logic [7:0]  fill;
		crc_mode_t   mode;
		logic        typed;   // 1: verdict typed in below, 0: taken from the predictor
		verdict_t    exp;
	} plan_row_t;

	localparam int PLAN_ROWS = 20;

	// Directed stimulus. All rows run with the seed left at its reset value.
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// single byte straight after reset, both data extremes
		'{9'd1,   64'h0000000000000000, 8'h00, CRC_RAW,  1'b1,
			'{ST_SHORT,   8'h00, 16'h0000, 8'h00, 7'd1}},
		'{9'd1,   64'hFF00000000000000, 8'h00, CRC_RAW,  1'b1,
			'{ST_SHORT,   8'h00, 16'h0000, 8'h00, 7'd1}},
		// header one byte short: fields captured so far are still reported
		'{9'd7,   64'hAC01FF99ABCD1200, 8'h00, CRC_RAW,  1'b1,
			'{ST_SHORT,   8'h99, 16'hABCD, 8'hFF, 7'd7}},
		'{9'd8,   64'h0001081112340000, 8'h00, CRC_RAW,  1'b1,
			'{ST_MAGIC,   8'h11, 16'h1234, 8'h08, 7'd8}},
		'{9'd8,   64'hAC020812FFFF0000, 8'h00, CRC_RAW,  1'b1,
			'{ST_VERSION, 8'h12, 16'hFFFF, 8'h08, 7'd8}},
		'{9'd12,  64'hAC010C9900000000, 8'h00, CRC_FLIP, 1'b1,
			'{ST_CRC,     8'h99, 16'h0000, 8'h0C, 7'd12}},
		// length field above the received count
		'{9'd8,   64'hAC01203155AA0000, 8'h00, CRC_GOOD, 1'b1,
			'{ST_LENGTH,  8'h31, 16'h55AA, 8'h20, 7'd8}},
		'{9'd8,   64'hAC01080001020000, 8'h00, CRC_GOOD, 1'b1,
			'{ST_TYPE,    8'h00, 16'h0102, 8'h08, 7'd8}},
		'{9'd8,   64'hAC0108FF80010000, 8'h00, CRC_GOOD, 1'b1,
			'{ST_TYPE,    8'hFF, 16'h8001, 8'h08, 7'd8}},
		// every known type accepted
		'{9'd8,   64'hAC01081100010000, 8'h00, CRC_GOOD, 1'b1,
			'{ST_OK,      8'h11, 16'h0001, 8'h08, 7'd8}},
		'{9'd9,   64'hAC0109127FFF0000, 8'h00, CRC_GOOD, 1'b1,
			'{ST_OK,      8'h12, 16'h7FFF, 8'h09, 7'd9}},
		'{9'd16,  64'hAC011099FFFE0000, 8'hFF, CRC_GOOD, 1'b1,
			'{ST_OK,      8'h99, 16'hFFFE, 8'h10, 7'd16}},
		'{9'd8,   64'hAC01083100000000, 8'h00, CRC_GOOD, 1'b1,
			'{ST_OK,      8'h31, 16'h0000, 8'h08, 7'd8}},
		// length field below the received count is fine
		'{9'd20,  64'hAC010011FFFF0000, 8'hFF, CRC_GOOD, 1'b1,
			'{ST_OK,      8'h11, 16'hFFFF, 8'h00, 7'd20}},
		// longest packet accepted, then one byte over
		'{9'd127, 64'hAC017F9912340000, 8'hA5, CRC_GOOD, 1'b1,
			'{ST_OK,      8'h99, 16'h1234, 8'h7F, 7'd127}},
		'{9'd128, 64'hAC01803143210000, 8'h5A, CRC_GOOD, 1'b1,
			'{ST_LONG,    8'h31, 16'h4321, 8'h80, 7'd127}},
		// byte counter runs into saturation; too long wins over a bad header
		'{9'd260, 64'h0000000000000000, 8'hFF, CRC_RAW,  1'b1,
			'{ST_LONG,    8'h00, 16'h0000, 8'h00, 7'd127}},
		'{9'd10,  64'hAC010A121357FFFF, 8'h00, CRC_RAW,  1'b0,
			'{ST_OK,      8'h00, 16'h0000, 8'h00, 7'd0}},
		'{9'd9,   64'hAC01FF12AA550000, 8'h00, CRC_GOOD, 1'b1,
			'{ST_LENGTH,  8'h12, 16'hAA55, 8'hFF, 7'd9}},
		'{9'd30,  64'hAC011E31C33C0000, 8'h3C, CRC_GOOD, 1'b0,
			'{ST_OK,      8'h00, 16'h0000, 8'h00, 7'd0}}
	};

	logic clk;
	logic arst_n;

	spv_byte_if    pkt_ch ();
	spv_verdict_if vd_ch ();
	spv_seed_if    seed_ch ();

	sensor_packet_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.verdict(vd_ch),
		.seed   (seed_ch)
	);

	// Percent of cycles in which each side holds back
	int unsigned src_idle;
	int unsigned snk_idle;
	// Receiver hold-off, in cycles, counted down by the receiver process
	int unsigned rx_hold;
	int unsigned mismatches;

	logic [7:0] frame[$];              // packet being sent, in wire order
	verdict_t   pending_verdicts[$];   // verdicts owed by the block, oldest first

	// Predictor copy of the block: seed register and the per-packet state
	logic [15:0] cur_seed;
	logic [7:0]  p_count;
	logic [15:0] p_crc;
	logic [7:0]  p_magic;
	logic [7:0]  p_version;
	logic [7:0]  p_len;
	logic [7:0]  p_type;
	logic [15:0] p_node;
	logic [15:0] p_crc_rx;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit, well above the slowest legal run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// CRC-16, polynomial 0x1021, one bit at a time, MSB of the byte first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		int          k;
		r = crc;
		for (k = 7; k >= 0; k--) begin
			fb = r[15] ^ b[k];
			r = {r[14:0], 1'b0};
			if (fb)
				r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	function automatic void clear_packet_state();
		p_count  = 8'd0;
		p_crc    = cur_seed;
		p_magic  = 8'd0;
		p_version = 8'd0;
		p_len    = 8'd0;
		p_type   = 8'd0;
		p_node   = 16'd0;
		p_crc_rx = 16'd0;
	endfunction

	// Advances the predictor by one byte; returns 1 with the verdict on a last byte
	function automatic bit predict_verdict(input logic [7:0] b, input logic last,
		output verdict_t v);
		logic [15:0] c;
		logic [7:0]  fed;
		status_t     st;
		v   = '0;
		c   = (p_count == 8'd0) ? cur_seed : p_crc;
		fed = b;
		case (p_count)
			POS_MAGIC:   p_magic = b;
			POS_VERSION: p_version = b;
			POS_LENGTH:  p_len = b;
			POS_TYPE:    p_type = b;
			POS_NODE_HI: p_node[15:8] = b;
			POS_NODE_LO: p_node[7:0] = b;
			// the CRC bytes themselves enter the CRC as zero
			POS_CRC_HI: begin
				p_crc_rx[15:8] = b;
				fed = 8'h00;
			end
			POS_CRC_LO: begin
				p_crc_rx[7:0] = b;
				fed = 8'h00;
			end
			default: ;
		endcase
		p_crc = crc_step(c, fed);
		if (p_count != COUNT_SAT)
			p_count = p_count + 8'd1;
		if (!last)
			return 1'b0;

		if (p_count > MAX_PACKET_BYTES)
			st = ST_LONG;
		else if (p_count < HDR_BYTES)
			st = ST_SHORT;
		else if (p_magic != MAGIC_VALUE)
			st = ST_MAGIC;
		else if (p_version != VERSION_VALUE)
			st = ST_VERSION;
		else if (p_crc_rx != p_crc)
			st = ST_CRC;
		else if (p_count < p_len)
			st = ST_LENGTH;
		else if (p_type != TYPE_A && p_type != TYPE_B && p_type != TYPE_C && p_type != TYPE_D)
			st = ST_TYPE;
		else
			st = ST_OK;

		v.status = st;
		v.mtype  = p_type;
		v.node   = p_node;
		v.len    = p_len;
		v.rx     = (p_count > LEN_OUT_MAX) ? LEN_OUT_MAX[6:0] : p_count[6:0];
		clear_packet_state();
		return 1'b1;
	endfunction

	// Writes a matching CRC, XORed with flip, into bytes 6 and 7 of the frame
	function automatic void seal_crc(input logic [15:0] flip);
		logic [15:0] c;
		int          i;
		if (frame.size() < int'(HDR_BYTES))
			return;
		c = cur_seed;
		for (i = 0; i < frame.size(); i++)
			c = crc_step(c, (i == int'(POS_CRC_HI) || i == int'(POS_CRC_LO)) ? 8'h00 : frame[i]);
		c = c ^ flip;
		frame[POS_CRC_HI] = c[15:8];
		frame[POS_CRC_LO] = c[7:0];
	endfunction

	// Random packet: mostly well formed with random content, some with one fault,
	// some pure noise. Lengths are mostly small, now and then around the limit.
	function automatic void random_frame();
		int unsigned n;
		int unsigned kind;
		int unsigned i;
		logic [7:0]  head[8];
		logic [15:0] flip;
		kind = $urandom_range(15);
		i    = $urandom_range(19);
		if (i == 0)
			n = $urandom_range(140, 100);
		else if (i < 4)
			n = $urandom_range(7, 1);
		else
			n = $urandom_range(24, 8);
		frame.delete();

		if (kind == 5) begin
			for (i = 0; i < n; i++)
				frame.push_back(8'($urandom_range(255)));
			return;
		end

		head[POS_MAGIC]   = MAGIC_VALUE;
		head[POS_VERSION] = VERSION_VALUE;
		head[POS_LENGTH]  = 8'($urandom_range(n, 0));
		case ($urandom_range(3))
			0: head[POS_TYPE] = TYPE_A;
			1: head[POS_TYPE] = TYPE_B;
			2: head[POS_TYPE] = TYPE_C;
			default: head[POS_TYPE] = TYPE_D;
		endcase
		head[POS_NODE_HI] = 8'($urandom_range(255));
		head[POS_NODE_LO] = 8'($urandom_range(255));
		head[POS_CRC_HI]  = 8'h00;
		head[POS_CRC_LO]  = 8'h00;
		flip = 16'h0000;
		case (kind)
			0: head[POS_MAGIC] = 8'($urandom_range(255));
			1: head[POS_VERSION] = 8'($urandom_range(255));
			2: flip = 16'($urandom_range(65535, 1));
			3: head[POS_LENGTH] = 8'($urandom_range(255, n + 1));
			4: head[POS_TYPE] = 8'($urandom_range(255));
			default: ;
		endcase
		for (i = 0; i < n; i++)
			frame.push_back(i < 8 ? head[i] : 8'($urandom_range(255)));
		seal_crc(flip);
	endfunction

	// Sends the frame, one transaction per byte, and books the verdict it owes
	task automatic send_frame(input bit typed, input verdict_t fixed);
		int       i;
		verdict_t v;
		for (i = 0; i < frame.size(); i++) begin
			@(negedge clk);
			while ($urandom_range(99) < src_idle) begin
				pkt_ch.valid = 1'b0;
				@(negedge clk);
			end
			pkt_ch.valid     = 1'b1;
			pkt_ch.data_byte = frame[i];
			pkt_ch.last_byte = (i == frame.size() - 1);
			do
				@(posedge clk);
			while (pkt_ch.ready !== 1'b1);
			// typed rows still step the predictor to keep its state in line
			if (predict_verdict(frame[i], pkt_ch.last_byte, v))
				pending_verdicts.push_back(typed ? fixed : v);
		end
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned sent;
		sent = 0;
		while (sent < budget) begin
			random_frame();
			send_frame(1'b0, '0);
			sent += frame.size();
		end
	endtask

	// Drop valid, wait for every owed verdict, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		pkt_ch.valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_seed(input logic [15:0] value);
		@(negedge clk);
		seed_ch.valid = 1'b1;
		seed_ch.data  = value;
		do
			@(posedge clk);
		while (seed_ch.ready !== 1'b1);
		cur_seed = value;
		clear_packet_state();
		@(negedge clk);
		seed_ch.valid = 1'b0;
	endtask

	// Verdict receiver: ready changes on the falling edge, either held off for a
	// counted stretch or dropped at random
	initial begin
		vd_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold != 0) begin
				vd_ch.ready = 1'b0;
				rx_hold--;
			end else begin
				vd_ch.ready = ($urandom_range(99) >= snk_idle);
			end
		end
	end

	// Verdict checker: every accepted verdict against the oldest one owed
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (vd_ch.valid === 1'b1 && vd_ch.ready === 1'b1) begin
			got.status = status_t'(vd_ch.status);
			got.mtype  = vd_ch.message_type;
			got.node   = vd_ch.source_node;
			got.len    = vd_ch.length_field;
			got.rx     = vd_ch.received_length;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: verdict with none owed: st=%0d type=%h node=%h len=%h rx=%0d",
						$time, got.status, got.mtype, got.node, got.len, got.rx);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.status !== want.status || got.mtype !== want.mtype ||
					got.node !== want.node || got.len !== want.len || got.rx !== want.rx) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: verdict mismatch: expected st=%0d type=%h node=%h ",
							"len=%h rx=%0d, got st=%0d type=%h node=%h len=%h rx=%0d"},
							$time, want.status, want.mtype, want.node, want.len, want.rx,
							got.status, got.mtype, got.node, got.len, got.rx);
				end
			end
		end
	end

	initial begin
		int r;
		int i;
		arst_n           = 1'b0;
		pkt_ch.valid     = 1'b0;
		pkt_ch.data_byte = 8'h00;
		pkt_ch.last_byte = 1'b0;
		seed_ch.valid    = 1'b0;
		seed_ch.data     = 16'h0000;
		rx_hold          = 0;
		mismatches       = 0;
		src_idle         = 21;
		snk_idle         = 87;
		cur_seed         = SEED_AT_RESET;
		clear_packet_state();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, seed at its reset value
		for (r = 0; r < PLAN_ROWS; r++) begin
			frame.delete();
			for (i = 0; i < PLAN[r].nbytes; i++)
				frame.push_back(i < 8 ? PLAN[r].hdr[63 - 8*i -: 8] : PLAN[r].fill);
			if (PLAN[r].mode != CRC_RAW)
				seal_crc((PLAN[r].mode == CRC_FLIP) ? 16'h0001 : 16'h0000);
			send_frame(PLAN[r].typed, PLAN[r].exp);
		end

		// Sender mostly busy, receiver mostly stalled; seed at its low extreme
		settle();
		write_seed(16'h0000);
		run_random(140);

		// Roles swapped; seed at its high extreme
		settle();
		src_idle = 87;
		snk_idle = 21;
		write_seed(16'hFFFF);
		run_random(140);

		// No idling. First a long receiver hold-off against a stream of one-byte
		// packets, so that verdicts back up and the input stalls.
		settle();
		src_idle = 0;
		snk_idle = 0;
		write_seed(16'($urandom_range(65535)));
		rx_hold = 300;
		for (i = 0; i < 40; i++) begin
			frame.delete();
			frame.push_back(8'($urandom_range(255)));
			send_frame(1'b0, '0);
		end
		run_random(140);

		settle();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
